[rtl/lwsc_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and helpers of the sector cache tag engine.
// No dependencies; every other file but lwsc_ram imports this package.
package lwsc_pkg;

	localparam int ENTRIES      = 64;
	localparam int SECTOR_BYTES = 512;
	localparam int IDX_W        = $clog2(ENTRIES);
	localparam int OCC_W        = $clog2(ENTRIES + 1);
	localparam int TAG_W        = 32;
	localparam int SLOT_W       = 6;
	localparam int MODE_W       = 2;
	localparam int OFF_W        = 9;
	localparam int LEN_W        = 10;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [OCC_W-1:0] occ_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_READ      = 2'd0,
		MODE_WRITE     = 2'd1,
		MODE_FLUSH     = 2'd2,
		MODE_FLUSH_INV = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		CMD_READ,
		CMD_WRITE,
		CMD_FLUSH,
		CMD_FLUSH_INV,
		CMD_RANGE_ERR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [TAG_W-1:0]   sector;
		logic               partial;
	} cmd_t;

	typedef struct packed {
		logic               hit;
		logic [SLOT_W-1:0]  slot;
		logic               fill_needed;
		logic               writeback_valid;
		logic [TAG_W-1:0]   writeback_sector;
		logic               range_error;
		logic               last;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE,
		ST_RESP,
		ST_FSTART,
		ST_FSCAN,
		ST_FEMIT
	} state_t;

	function automatic idx_t first_set(input logic [ENTRIES-1:0] v);
		idx_t r;
		r = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (v[i]) r = IDX_W'(i);
		end
		return r;
	endfunction

endpackage

[rtl/lwsc_if.sv]
`timescale 1ns / 1ps
// Request and result channel interfaces of the sector cache tag engine.
// Depends on lwsc_pkg for field widths.
interface lwsc_req_if import lwsc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [TAG_W-1:0]   sector;
	logic [OFF_W-1:0]   byte_offset;
	logic [LEN_W-1:0]   byte_count;

	modport source(output valid, mode, sector, byte_offset, byte_count, input ready);
	modport sink(input valid, mode, sector, byte_offset, byte_count, output ready);
endinterface

interface lwsc_res_if import lwsc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               hit;
	logic [SLOT_W-1:0]  slot;
	logic               fill_needed;
	logic               writeback_valid;
	logic [TAG_W-1:0]   writeback_sector;
	logic               range_error;
	logic               last;

	modport source(output valid, hit, slot, fill_needed, writeback_valid, writeback_sector,
		range_error, last, input ready);
	modport sink(input valid, hit, slot, fill_needed, writeback_valid, writeback_sector,
		range_error, last, output ready);
endinterface

[rtl/lwsc_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read (read-first).
// No dependencies.
module lwsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

[rtl/lwsc_front.sv]
`timescale 1ns / 1ps
// Front end: accepts requests, checks the byte range, classifies them and
// queues the commands for the back end. Depends on lwsc_pkg and lwsc_if.
module lwsc_front import lwsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	lwsc_req_if.sink    req,
	output cmd_t        cmd,
	output logic        cmd_valid,
	input  logic        cmd_ready
);

	logic [LEN_W:0] span;
	logic           range_bad;
	cmd_t           cmd_in;
	cmd_t           fifo_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           push;
	logic           pop;

	always_comb begin
		span           = (LEN_W+1)'(req.byte_offset) + (LEN_W+1)'(req.byte_count);
		range_bad      = span > (LEN_W+1)'(SECTOR_BYTES);
		cmd_in.sector  = req.sector;
		cmd_in.partial = (req.byte_offset != '0) || (req.byte_count < LEN_W'(SECTOR_BYTES));
		unique case (mode_t'(req.mode))
			MODE_READ:      cmd_in.kind = range_bad ? CMD_RANGE_ERR : CMD_READ;
			MODE_WRITE:     cmd_in.kind = range_bad ? CMD_RANGE_ERR : CMD_WRITE;
			MODE_FLUSH:     cmd_in.kind = CMD_FLUSH;
			MODE_FLUSH_INV: cmd_in.kind = CMD_FLUSH_INV;
			default:        cmd_in.kind = CMD_READ;
		endcase
	end

	assign req.ready = cnt_q != 2'd2;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = fifo_q[rd_ptr_q];
	assign push      = req.valid && req.ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= cmd_in;
	end

endmodule

[rtl/lwsc_back.sv]
`timescale 1ns / 1ps
// Back end: tag match, LRU ranks, valid/dirty state, flush walk and the
// result register. Depends on lwsc_pkg, lwsc_if and lwsc_ram.
module lwsc_back import lwsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	lwsc_res_if.source  res
);

	state_t             state_q, state_d;
	logic [ENTRIES-1:0] valid_q, dirty_q;
	logic [TAG_W-1:0]   tag_q [ENTRIES];
	idx_t               rank_q [ENTRIES];
	occ_t               occ_q;
	cmd_t               cmd_q;
	idx_t               sel_q;
	idx_t               hit_rank_q;
	logic               hit_q, evict_q, wb_q;
	idx_t               scan_q;
	occ_t               dcnt_q;
	logic               out_valid_q;
	result_t            out_q;

	logic [ENTRIES-1:0] hit_vec, free_vec, lru_vec, scan_vec;
	idx_t               hit_rank;
	idx_t               scan_idx;
	logic               scan_hit;
	logic               out_free;
	logic               load_out;
	logic               flush_done;
	result_t            out_d;
	logic               ram_re, ram_we;
	idx_t               ram_raddr;
	logic [TAG_W-1:0]   ram_rdata;
	occ_t               limit;

	always_comb begin
		hit_rank = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_vec[i]  = valid_q[i] && (tag_q[i] == cmd_q.sector);
			free_vec[i] = !valid_q[i];
			lru_vec[i]  = valid_q[i] && (rank_q[i] == IDX_W'(occ_q - OCC_W'(1)));
			scan_vec[i] = valid_q[i] && (rank_q[i] == scan_q);
			hit_rank    = hit_rank | ({IDX_W{hit_vec[i]}} & rank_q[i]);
		end
		scan_idx = first_set(scan_vec);
		scan_hit = scan_vec != '0;
		limit    = hit_q ? OCC_W'(hit_rank_q) : OCC_W'(ENTRIES);
	end

	assign out_free = !out_valid_q || res.ready;

	always_comb begin
		state_d    = state_q;
		cmd_ready  = 1'b0;
		load_out   = 1'b0;
		flush_done = 1'b0;
		out_d      = '0;
		ram_re     = 1'b0;
		ram_we     = 1'b0;
		ram_raddr  = sel_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					unique case (cmd.kind)
						CMD_READ, CMD_WRITE:      state_d = ST_LOOKUP;
						CMD_FLUSH, CMD_FLUSH_INV: state_d = ST_FSTART;
						default:                  state_d = ST_RESP;
					endcase
				end
			end
			ST_LOOKUP: state_d = ST_UPDATE;
			ST_UPDATE: begin
				ram_re  = 1'b1;
				ram_we  = !hit_q;
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (out_free) begin
					load_out   = 1'b1;
					out_d.last = 1'b1;
					unique case (cmd_q.kind)
						CMD_READ, CMD_WRITE: begin
							out_d.hit              = hit_q;
							out_d.slot             = SLOT_W'(sel_q);
							out_d.fill_needed      = !hit_q &&
								(cmd_q.kind == CMD_READ || cmd_q.partial);
							out_d.writeback_valid  = wb_q;
							out_d.writeback_sector = wb_q ? ram_rdata : '0;
						end
						CMD_FLUSH, CMD_FLUSH_INV: flush_done = 1'b1;
						default: out_d.range_error = 1'b1;
					endcase
					state_d = ST_IDLE;
				end
			end
			ST_FSTART: state_d = ((valid_q & dirty_q) == '0) ? ST_RESP : ST_FSCAN;
			ST_FSCAN: begin
				if (scan_hit && dirty_q[scan_idx]) begin
					ram_re    = 1'b1;
					ram_raddr = scan_idx;
					state_d   = ST_FEMIT;
				end
			end
			ST_FEMIT: begin
				if (out_free) begin
					load_out               = 1'b1;
					out_d.slot             = SLOT_W'(sel_q);
					out_d.writeback_valid  = 1'b1;
					out_d.writeback_sector = ram_rdata;
					out_d.last             = dcnt_q == OCC_W'(1);
					if (out_d.last) begin
						flush_done = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						state_d = ST_FSCAN;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	lwsc_ram #(
		.WIDTH (TAG_W),
		.DEPTH (ENTRIES)
	) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (sel_q),
		.wdata (cmd_q.sector),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			dirty_q     <= '0;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) out_valid_q <= 1'b1;
			else if (res.ready) out_valid_q <= 1'b0;
			if (state_q == ST_UPDATE) begin
				if (hit_q) begin
					dirty_q[sel_q] <= dirty_q[sel_q] || (cmd_q.kind == CMD_WRITE);
				end else begin
					valid_q[sel_q] <= 1'b1;
					dirty_q[sel_q] <= cmd_q.kind == CMD_WRITE;
					if (!evict_q) occ_q <= occ_q + OCC_W'(1);
				end
			end
			if (state_q == ST_FSCAN && scan_hit && dirty_q[scan_idx]) begin
				dirty_q[scan_idx] <= 1'b0;
			end
			if (flush_done && cmd_q.kind == CMD_FLUSH_INV) begin
				valid_q <= '0;
				dirty_q <= '0;
				occ_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) out_q <= out_d;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) cmd_q <= cmd;
			end
			ST_LOOKUP: begin
				hit_q      <= hit_vec != '0;
				hit_rank_q <= hit_rank;
				evict_q    <= occ_q == OCC_W'(ENTRIES);
				if (hit_vec != '0) sel_q <= first_set(hit_vec);
				else if (occ_q != OCC_W'(ENTRIES)) sel_q <= first_set(free_vec);
				else sel_q <= first_set(lru_vec);
			end
			ST_UPDATE: begin
				wb_q <= !hit_q && evict_q && dirty_q[sel_q];
				for (int i = 0; i < ENTRIES; i++) begin
					if (valid_q[i] && IDX_W'(i) != sel_q && OCC_W'(rank_q[i]) < limit) begin
						rank_q[i] <= rank_q[i] + IDX_W'(1);
					end
				end
				rank_q[sel_q] <= '0;
				if (!hit_q) tag_q[sel_q] <= cmd_q.sector;
			end
			ST_FSTART: begin
				dcnt_q <= OCC_W'($countones(valid_q & dirty_q));
				scan_q <= IDX_W'(occ_q - OCC_W'(1));
			end
			ST_FSCAN: begin
				if (scan_hit && dirty_q[scan_idx]) sel_q <= scan_idx;
				else scan_q <= scan_q - IDX_W'(1);
			end
			ST_FEMIT: begin
				if (out_free) begin
					dcnt_q <= dcnt_q - OCC_W'(1);
					scan_q <= scan_q - IDX_W'(1);
				end
			end
			default: ;
		endcase
	end

	assign res.valid            = out_valid_q;
	assign res.hit              = out_q.hit;
	assign res.slot             = out_q.slot;
	assign res.fill_needed      = out_q.fill_needed;
	assign res.writeback_valid  = out_q.writeback_valid;
	assign res.writeback_sector = out_q.writeback_sector;
	assign res.range_error      = out_q.range_error;
	assign res.last             = out_q.last;

	a_occ_max: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(ENTRIES))
		else $error("occupancy above capacity");

	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		OCC_W'($countones(valid_q)) == occ_q)
		else $error("occupancy does not match valid entries");

	a_dirty_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(dirty_q & ~valid_q) == '0)
		else $error("dirty entry not valid");

	a_femit_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FEMIT |-> dcnt_q != '0)
		else $error("flush emit with no dirty entries left");

endmodule

[rtl/lru_writeback_sector_cache_tags.sv]
`timescale 1ns / 1ps
// Read/write request: the back end takes it in idle, then runs the lookup, update and
// result steps; it takes no new command until that result is registered.
// Flush: a start step, then a walk over the LRU ranks that emits each dirty entry.
// A two-deep command queue lets requests be accepted while the engine works.
// Reset (arst_n low) empties the cache at once; no clearing pass is needed.
module lru_writeback_sector_cache_tags import lwsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	lwsc_req_if.sink    req,
	lwsc_res_if.source  res
);

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_ready;

	lwsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready)
	);

	lwsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.res       (res)
	);

endmodule
